[sv/sts_pkg.sv]
// Shared types and constants for the source threat scoring table.
// No dependencies; imported by the top level and the bench.
package sts_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SCORE,
      ST_WRITE,
      ST_SWCHK,
      ST_SWEEP,
      ST_DONE
   } state_type;

   localparam logic [1:0] KIND_EVENT = 2'd0;
   localparam logic [1:0] KIND_TICK  = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;

   localparam logic [3:0] EV_AUTH      = 4'd0;
   localparam logic [3:0] EV_LIMIT     = 4'd1;
   localparam logic [3:0] EV_INVALID   = 4'd2;
   localparam logic [3:0] EV_PROTO_MIN = 4'd3;
   localparam logic [3:0] EV_PROTO_MAX = 4'd8;

   localparam logic [2:0] REG_AUTH_HI    = 3'd0;
   localparam logic [2:0] REG_AUTH_LO    = 3'd1;
   localparam logic [2:0] REG_LIMIT_HI   = 3'd2;
   localparam logic [2:0] REG_LIMIT_LO   = 3'd3;
   localparam logic [2:0] REG_INVALID_HI = 3'd4;
   localparam logic [2:0] REG_INVALID_LO = 3'd5;
   localparam logic [2:0] REG_WINDOW     = 3'd6;
   localparam logic [2:0] REG_SWEEP      = 3'd7;

   localparam logic [1:0] LVL_LOW      = 2'd0;
   localparam logic [1:0] LVL_MEDIUM   = 2'd1;
   localparam logic [1:0] LVL_HIGH     = 2'd2;
   localparam logic [1:0] LVL_CRITICAL = 2'd3;

   localparam logic [31:0] MS_PER_HOUR = 32'd3600000;
   localparam logic [31:0] MIN_SPAN_MS = 32'd36000;
   localparam logic [31:0] PROTO_RATE  = 32'd5;
   localparam logic [63:0] STALE_MS    = 64'd172800000;
   localparam logic [6:0]  REMOVED_MAX = 7'd127;

endpackage

[sv/sts_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module sts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[sv/source_threat_scoring_table_core.sv]
// Source threat scoring table: top level with sequencer and shared multiplier.
// Depends on sts_pkg and sts_ram.
//
// Usage: requests enter on req_* (valid/ready); one response per request
// leaves on rsp_* (valid/ready). Registers are written through csr_*; the user
// must write them only while the block is idle, the block itself does not
// enforce it. req_ready is high only while the sequencer is idle.
// Work per request:
//   query:  key search, one table entry read per cycle, ends on a match
//   event:  key search, scoring in steps on the one 32x32 multiplier and a
//           write of the entry (both skipped when the table is full), then
//           a sweep check and, when due, a sweep over the table
//   tick:   sweep check plus the sweep when due
// Search and sweep both walk the entry RAM through its single read port.
// Reset clears the valid bits and the sweep time and sets the registers to
// their defaults at once; no clearing pass is needed. A response that waits in
// the output register does not block the next request; the sequencer holds in
// its final state until the output register is free.
module source_threat_scoring_table_core #(
   parameter int TABLE_ENTRIES = 64,
   parameter int COUNT_BITS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [63:0] req_source_addr_high,
   input  logic [63:0] req_source_addr_low,
   input  logic [3:0]  req_event_type,
   input  logic [63:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_threat_level,
   output logic        rsp_level_changed,
   output logic        rsp_significant,
   output logic        rsp_entry_found,
   output logic        rsp_table_full,
   output logic [6:0]  rsp_removed_count,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import sts_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = IDX_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(TABLE_ENTRIES);

   typedef struct packed {
      logic [63:0]           key_high;
      logic [63:0]           key_low;
      logic [63:0]           first_seen;
      logic [63:0]           last_active;
      logic [COUNT_BITS-1:0] auth_cnt;
      logic [COUNT_BITS-1:0] limit_cnt;
      logic [COUNT_BITS-1:0] invalid_cnt;
      logic [COUNT_BITS-1:0] proto_cnt;
      logic [COUNT_BITS-1:0] packet_cnt;
      logic [1:0]            level;
   } rec_type;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   // configuration
   logic [15:0] reg16_ff [6];
   logic [31:0] window_ff, sweep_iv_ff;

   // request latch
   logic [1:0]  kind_ff;
   logic [63:0] key_hi_ff, key_lo_ff, now_ff;
   logic [3:0]  ev_ff;

   // sequencer
   state_type state_ff, state_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             free_vld_ff, free_vld_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [IDX_W-1:0] ent_idx_ff, ent_idx_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [63:0] last_sweep_ff, last_sweep_in;
   logic [63:0] cutoff_ff, cutoff_in;

   // scoring
   rec_type     rec_ff, rec_in;
   logic [1:0]  prev_lvl_ff, prev_lvl_in;
   logic [31:0] span_ff, span_in;
   logic [3:0]  mstep_ff, mstep_in;
   logic [63:0] prod_ff, lhs_ff, lhs_in;
   logic        hi_hit_ff, hi_hit_in;
   logic [3:0]  pts_ff, pts_in;
   logic [31:0] mul_a, mul_b;

   // result staging and output register
   logic [1:0] res_lvl_ff, res_lvl_in;
   logic       res_chg_ff, res_chg_in, res_sig_ff, res_sig_in;
   logic       res_found_ff, res_found_in, res_full_ff, res_full_in;
   logic [6:0] res_rem_ff, res_rem_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_lvl_ff, rsp_lvl_in;
   logic       rsp_chg_ff, rsp_chg_in, rsp_sig_ff, rsp_sig_in;
   logic       rsp_found_ff, rsp_found_in, rsp_full_ff, rsp_full_in;
   logic [6:0] rsp_rem_ff, rsp_rem_in;

   // RAM
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr, ram_raddr;
   rec_type          ram_wdata, ram_rdata;

   // helpers
   logic             accept, issue, last_cmp, key_match, out_free;
   rec_type          base_rec, upd_rec;
   logic [63:0]      span_raw;
   logic [1:0]       new_lvl;
   logic [63:0]      since_sweep;

   sts_ram #(.WIDTH($bits(rec_type)), .DEPTH(TABLE_ENTRIES)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign issue     = (state_ff == ST_SEARCH || state_ff == ST_SWEEP) && (scan_ff < ENTRIES_CNT);
   assign last_cmp  = cmp_vld_ff && (cmp_idx_ff == LAST_IDX);
   assign key_match = cmp_vld_ff && valid_ff[cmp_idx_ff] &&
                      (ram_rdata.key_high == key_hi_ff) && (ram_rdata.key_low == key_lo_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign ram_raddr = scan_ff[IDX_W-1:0];
   assign since_sweep = now_ff - last_sweep_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         reg16_ff[REG_AUTH_HI]    <= 16'd100;
         reg16_ff[REG_AUTH_LO]    <= 16'd10;
         reg16_ff[REG_LIMIT_HI]   <= 16'd100;
         reg16_ff[REG_LIMIT_LO]   <= 16'd10;
         reg16_ff[REG_INVALID_HI] <= 16'd100;
         reg16_ff[REG_INVALID_LO] <= 16'd10;
         window_ff   <= 32'd3600000;
         sweep_iv_ff <= 32'd300000;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_WINDOW: window_ff   <= csr_wdata;
            REG_SWEEP:  sweep_iv_ff <= csr_wdata;
            default:    reg16_ff[csr_index] <= csr_wdata[15:0];
         endcase
      end
   end

   // build the record for the event: found entry or fresh one
   always_comb begin
      if (key_match) begin
         base_rec = ram_rdata;
      end else begin
         base_rec = '0;
         base_rec.key_high   = key_hi_ff;
         base_rec.key_low    = key_lo_ff;
         base_rec.first_seen = now_ff;
      end
      upd_rec = base_rec;
      upd_rec.last_active = now_ff;
      upd_rec.packet_cnt  = sat_inc(base_rec.packet_cnt);
      case (ev_ff) inside
         EV_AUTH:    upd_rec.auth_cnt    = sat_inc(base_rec.auth_cnt);
         EV_LIMIT:   upd_rec.limit_cnt   = sat_inc(base_rec.limit_cnt);
         EV_INVALID: upd_rec.invalid_cnt = sat_inc(base_rec.invalid_cnt);
         [EV_PROTO_MIN:EV_PROTO_MAX]:
            upd_rec.proto_cnt = sat_inc(base_rec.proto_cnt);
         default: ;
      endcase
      span_raw = (now_ff > base_rec.first_seen) ? now_ff - base_rec.first_seen : 64'd0;
   end

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = span_ff;
      case (mstep_ff)
         4'd0:  begin mul_a = 32'(rec_ff.auth_cnt);    mul_b = MS_PER_HOUR; end
         4'd1:  mul_a = 32'(reg16_ff[REG_AUTH_HI]);
         4'd2:  mul_a = 32'(reg16_ff[REG_AUTH_LO]);
         4'd3:  begin mul_a = 32'(rec_ff.limit_cnt);   mul_b = MS_PER_HOUR; end
         4'd4:  mul_a = 32'(reg16_ff[REG_LIMIT_HI]);
         4'd5:  mul_a = 32'(reg16_ff[REG_LIMIT_LO]);
         4'd6:  begin mul_a = 32'(rec_ff.invalid_cnt); mul_b = MS_PER_HOUR; end
         4'd7:  mul_a = 32'(reg16_ff[REG_INVALID_HI]);
         4'd8:  mul_a = 32'(reg16_ff[REG_INVALID_LO]);
         4'd9:  begin mul_a = 32'(rec_ff.proto_cnt);   mul_b = MS_PER_HOUR; end
         4'd10: mul_a = PROTO_RATE;
         default: ;
      endcase
   end

   always_comb begin
      if (span_ff < MIN_SPAN_MS) new_lvl = LVL_LOW;
      else if (pts_ff >= 4'd6)   new_lvl = LVL_CRITICAL;
      else if (pts_ff >= 4'd4)   new_lvl = LVL_HIGH;
      else if (pts_ff >= 4'd2)   new_lvl = LVL_MEDIUM;
      else                       new_lvl = LVL_LOW;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_EVENT || req_kind == KIND_QUERY) state_in = ST_SEARCH;
               else if (req_kind == KIND_TICK) state_in = ST_SWCHK;
               else state_in = ST_DONE;
            end
         end
         ST_SEARCH: begin
            if (key_match || last_cmp) begin
               if (kind_ff == KIND_QUERY) state_in = ST_DONE;
               else if (key_match || free_vld_ff || !valid_ff[cmp_idx_ff]) state_in = ST_SCORE;
               else state_in = ST_SWCHK;
            end
         end
         ST_SCORE: if (mstep_ff == 4'd11) state_in = ST_WRITE;
         ST_WRITE: state_in = ST_SWCHK;
         ST_SWCHK: state_in = (since_sweep > 64'(sweep_iv_ff)) ? ST_SWEEP : ST_DONE;
         ST_SWEEP: if (last_cmp) state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      scan_in       = issue ? scan_ff + 1'b1 : scan_ff;
      cmp_vld_in    = issue;
      cmp_idx_in    = scan_ff[IDX_W-1:0];
      free_vld_in   = free_vld_ff;
      free_idx_in   = free_idx_ff;
      ent_idx_in    = ent_idx_ff;
      valid_in      = valid_ff;
      last_sweep_in = last_sweep_ff;
      cutoff_in     = cutoff_ff;
      rec_in        = rec_ff;
      prev_lvl_in   = prev_lvl_ff;
      span_in       = span_ff;
      mstep_in      = mstep_ff;
      lhs_in        = lhs_ff;
      hi_hit_in     = hi_hit_ff;
      pts_in        = pts_ff;
      res_lvl_in    = res_lvl_ff;
      res_chg_in    = res_chg_ff;
      res_sig_in    = res_sig_ff;
      res_found_in  = res_found_ff;
      res_full_in   = res_full_ff;
      res_rem_in    = res_rem_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_lvl_in    = rsp_lvl_ff;
      rsp_chg_in    = rsp_chg_ff;
      rsp_sig_in    = rsp_sig_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_rem_in    = rsp_rem_ff;
      ram_we        = 1'b0;
      ram_waddr     = ent_idx_ff;
      ram_wdata     = rec_ff;
      ram_wdata.level = new_lvl;

      unique case (state_ff)
         ST_IDLE: begin
            scan_in      = '0;
            free_vld_in  = 1'b0;
            res_lvl_in   = LVL_LOW;
            res_chg_in   = 1'b0;
            res_sig_in   = 1'b0;
            res_found_in = 1'b0;
            res_full_in  = 1'b0;
            res_rem_in   = '0;
         end
         ST_SEARCH: begin
            // remember the lowest free slot as the walk passes it
            if (cmp_vld_ff && !valid_ff[cmp_idx_ff] && !free_vld_ff) begin
               free_vld_in = 1'b1;
               free_idx_in = cmp_idx_ff;
            end
            if (key_match || last_cmp) begin
               mstep_in = '0;
               pts_in   = '0;
               if (kind_ff == KIND_QUERY) begin
                  res_found_in = key_match;
                  res_lvl_in   = key_match ? ram_rdata.level : LVL_LOW;
               end else if (key_match) begin
                  res_found_in = 1'b1;
                  ent_idx_in   = cmp_idx_ff;
               end else if (free_vld_ff) begin
                  ent_idx_in   = free_idx_ff;
               end else if (!valid_ff[cmp_idx_ff]) begin
                  ent_idx_in   = cmp_idx_ff;
               end else begin
                  res_full_in  = 1'b1;
               end
               rec_in      = upd_rec;
               prev_lvl_in = base_rec.level;
               span_in     = (span_raw > 64'(window_ff)) ? window_ff : span_raw[31:0];
            end
         end
         ST_SCORE: begin
            mstep_in = mstep_ff + 1'b1;
            case (mstep_ff)
               4'd1, 4'd4, 4'd7, 4'd10: lhs_in = prod_ff;
               4'd2, 4'd5, 4'd8:        hi_hit_in = (lhs_ff >= prod_ff);
               4'd3, 4'd6, 4'd9: begin
                  if (hi_hit_ff)             pts_in = pts_ff + 4'd3;
                  else if (lhs_ff >= prod_ff) pts_in = pts_ff + 4'd1;
               end
               4'd11: if (lhs_ff >= prod_ff) pts_in = pts_ff + 4'd2;
               default: ;
            endcase
         end
         ST_WRITE: begin
            ram_we               = 1'b1;
            valid_in[ent_idx_ff] = 1'b1;
            res_lvl_in = new_lvl;
            res_chg_in = (new_lvl != prev_lvl_ff);
            res_sig_in = (new_lvl != LVL_LOW) || (new_lvl != prev_lvl_ff);
         end
         ST_SWCHK: begin
            scan_in       = '0;
            last_sweep_in = (since_sweep > 64'(sweep_iv_ff)) ? now_ff : last_sweep_ff;
            cutoff_in     = (now_ff > STALE_MS) ? now_ff - STALE_MS : 64'd0;
         end
         ST_SWEEP: begin
            // drop stale entries whose level is low
            if (cmp_vld_ff && valid_ff[cmp_idx_ff] && (ram_rdata.last_active < cutoff_ff) &&
                (ram_rdata.level == LVL_LOW)) begin
               valid_in[cmp_idx_ff] = 1'b0;
               if (res_rem_ff != REMOVED_MAX) res_rem_in = res_rem_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_lvl_in   = res_lvl_ff;
               rsp_chg_in   = res_chg_ff;
               rsp_sig_in   = res_sig_ff;
               rsp_found_in = res_found_ff;
               rsp_full_in  = res_full_ff;
               rsp_rem_in   = res_rem_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         last_sweep_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         scan_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         last_sweep_ff <= last_sweep_in;
         rsp_valid_ff  <= rsp_valid_in;
         cmp_vld_ff    <= cmp_vld_in;
         scan_ff       <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= req_kind;
         key_hi_ff <= req_source_addr_high;
         key_lo_ff <= req_source_addr_low;
         ev_ff     <= req_event_type;
         now_ff    <= req_now_ms;
      end
      cmp_idx_ff   <= cmp_idx_in;
      free_vld_ff  <= free_vld_in;
      free_idx_ff  <= free_idx_in;
      ent_idx_ff   <= ent_idx_in;
      cutoff_ff    <= cutoff_in;
      rec_ff       <= rec_in;
      prev_lvl_ff  <= prev_lvl_in;
      span_ff      <= span_in;
      mstep_ff     <= mstep_in;
      prod_ff      <= 64'(mul_a) * 64'(mul_b);
      lhs_ff       <= lhs_in;
      hi_hit_ff    <= hi_hit_in;
      pts_ff       <= pts_in;
      res_lvl_ff   <= res_lvl_in;
      res_chg_ff   <= res_chg_in;
      res_sig_ff   <= res_sig_in;
      res_found_ff <= res_found_in;
      res_full_ff  <= res_full_in;
      res_rem_ff   <= res_rem_in;
      rsp_lvl_ff   <= rsp_lvl_in;
      rsp_chg_ff   <= rsp_chg_in;
      rsp_sig_ff   <= rsp_sig_in;
      rsp_found_ff <= rsp_found_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_rem_ff   <= rsp_rem_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_threat_level  = rsp_lvl_ff;
   assign rsp_level_changed = rsp_chg_ff;
   assign rsp_significant   = rsp_sig_ff;
   assign rsp_entry_found   = rsp_found_ff;
   assign rsp_table_full    = rsp_full_ff;
   assign rsp_removed_count = rsp_rem_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE) else $error("sequencer idle after accept");
   a_full_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_table_full && rsp_entry_found)) else $error("full and found");
   a_changed_sig: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_level_changed |-> rsp_significant) else $error("change not significant");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH || state_ff == ST_SWEEP |-> scan_ff <= ENTRIES_CNT)
      else $error("scan ran past table");
endmodule

[bench/source_threat_scoring_table_core_tb.sv]
// Self-checking bench for source_threat_scoring_table_core: drives requests and
// register writes, predicts each response and compares it field by field.
// Depends on sts_pkg and the RTL of the block.
`timescale 1ns / 100ps

module source_threat_scoring_table_core_tb;
   import sts_pkg::*;

   localparam logic [1:0]  KIND_RESERVED = 2'd3;
   localparam int          ENTRIES       = 64;
   localparam logic [31:0] COUNT_MAX     = 32'hFFFF_FFFF;
   localparam int          SETTLE        = 2 * ENTRIES + 60;
   localparam int          CYCLE_LIMIT   = 1000000;
   localparam int          POOL          = 80;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic [3:0]  ev;
      logic [63:0] now;
   } request_type;

   typedef struct packed {
      logic [1:0] level;
      logic       changed;
      logic       significant;
      logic       found;
      logic       full;
      logic [6:0] removed;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_kind = '0;
   logic [63:0] req_source_addr_high = '0;
   logic [63:0] req_source_addr_low = '0;
   logic [3:0]  req_event_type = '0;
   logic [63:0] req_now_ms = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_threat_level;
   logic        rsp_level_changed;
   logic        rsp_significant;
   logic        rsp_entry_found;
   logic        rsp_table_full;
   logic [6:0]  rsp_removed_count;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   source_threat_scoring_table_core dut (.*);

   // scoreboard state
   request_type pending_requests[$];
   verdict_type expected_verdicts[$];
   int       error_count = 0;
   int       accepted_count = 0;
   int       checked_count = 0;
   int       cycle_count = 0;
   int       send_idle_pct = 0;
   int       recv_stall_pct = 0;
   bit       long_hold_trigger = 0;
   bit       req_fire = 0;

   // predictor state
   logic [31:0] thresh[8];
   bit          slot_valid[ENTRIES];
   logic [63:0] slot_hi[ENTRIES], slot_lo[ENTRIES];
   logic [63:0] slot_first[ENTRIES], slot_last[ENTRIES];
   logic [31:0] slot_auth[ENTRIES], slot_limit[ENTRIES], slot_invalid[ENTRIES];
   logic [31:0] slot_proto[ENTRIES], slot_packets[ENTRIES];
   logic [1:0]  slot_level[ENTRIES];
   logic [63:0] last_sweep_ms;

   // stimulus helpers
   logic [63:0] key_hi[POOL], key_lo[POOL];
   logic [63:0] clock_ms;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [31:0] sat_inc(logic [31:0] v);
      return (v == COUNT_MAX) ? v : v + 32'd1;
   endfunction

   function automatic int rate_points(logic [31:0] cnt, logic [63:0] span,
                                      logic [31:0] hi, logic [31:0] lo);
      logic [63:0] lhs;
      lhs = 64'(cnt) * 64'(MS_PER_HOUR);
      if (lhs >= 64'(hi) * span) return 3;
      if (lhs >= 64'(lo) * span) return 1;
      return 0;
   endfunction

   function automatic logic [1:0] score_level(int e, logic [63:0] now);
      logic [63:0] span;
      int pts;
      span = (now > slot_first[e]) ? now - slot_first[e] : 64'd0;
      if (span > 64'(thresh[REG_WINDOW])) span = 64'(thresh[REG_WINDOW]);
      if (span < 64'(MIN_SPAN_MS)) return LVL_LOW;
      pts = rate_points(slot_auth[e], span, thresh[REG_AUTH_HI], thresh[REG_AUTH_LO]);
      pts += rate_points(slot_limit[e], span, thresh[REG_LIMIT_HI], thresh[REG_LIMIT_LO]);
      pts += rate_points(slot_invalid[e], span, thresh[REG_INVALID_HI],
                         thresh[REG_INVALID_LO]);
      if (64'(slot_proto[e]) * 64'(MS_PER_HOUR) >= 64'(PROTO_RATE) * span) pts += 2;
      if (pts >= 6) return LVL_CRITICAL;
      if (pts >= 4) return LVL_HIGH;
      if (pts >= 2) return LVL_MEDIUM;
      return LVL_LOW;
   endfunction

   function automatic int lookup_slot(logic [63:0] hi, logic [63:0] lo);
      for (int i = 0; i < ENTRIES; i++)
         if (slot_valid[i] && slot_hi[i] == hi && slot_lo[i] == lo) return i;
      return -1;
   endfunction

   function automatic logic [6:0] sweep_stale(logic [63:0] now);
      logic [63:0] cutoff;
      logic [6:0]  removed;
      removed = '0;
      if (now - last_sweep_ms <= 64'(thresh[REG_SWEEP])) return '0;
      cutoff = (now > STALE_MS) ? now - STALE_MS : 64'd0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_valid[i] && slot_last[i] < cutoff && slot_level[i] == LVL_LOW) begin
            slot_valid[i] = 0;
            if (removed != REMOVED_MAX) removed++;
         end
      end
      last_sweep_ms = now;
      return removed;
   endfunction

   function automatic verdict_type predict_verdict(request_type r);
      verdict_type v;
      int e;
      logic [1:0] nl;
      v = '0;
      case (r.kind)
         KIND_EVENT: begin
            e = lookup_slot(r.addr_hi, r.addr_lo);
            if (e >= 0) begin
               v.found = 1;
            end else begin
               for (int i = 0; i < ENTRIES && e < 0; i++) if (!slot_valid[i]) e = i;
               if (e >= 0) begin
                  slot_valid[e] = 1;
                  slot_hi[e] = r.addr_hi;
                  slot_lo[e] = r.addr_lo;
                  slot_first[e] = r.now;
                  slot_auth[e] = '0;
                  slot_limit[e] = '0;
                  slot_invalid[e] = '0;
                  slot_proto[e] = '0;
                  slot_packets[e] = '0;
                  slot_level[e] = LVL_LOW;
               end else begin
                  v.full = 1;
               end
            end
            if (e >= 0) begin
               slot_last[e] = r.now;
               slot_packets[e] = sat_inc(slot_packets[e]);
               if (r.ev == EV_AUTH) slot_auth[e] = sat_inc(slot_auth[e]);
               else if (r.ev == EV_LIMIT) slot_limit[e] = sat_inc(slot_limit[e]);
               else if (r.ev == EV_INVALID) slot_invalid[e] = sat_inc(slot_invalid[e]);
               else if (r.ev <= EV_PROTO_MAX) slot_proto[e] = sat_inc(slot_proto[e]);
               nl = score_level(e, r.now);
               v.changed = (nl != slot_level[e]);
               slot_level[e] = nl;
               v.level = nl;
               v.significant = (nl != LVL_LOW) || v.changed;
            end
            v.removed = sweep_stale(r.now);
         end
         KIND_TICK: v.removed = sweep_stale(r.now);
         KIND_QUERY: begin
            e = lookup_slot(r.addr_hi, r.addr_lo);
            if (e >= 0) begin
               v.found = 1;
               v.level = slot_level[e];
            end
         end
         default: ;
      endcase
      return v;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
      error_count++;
   endtask

   // monitor: predict on each accepted request, check each accepted response
   always @(posedge clock) begin
      verdict_type want;
      cycle_count <= cycle_count + 1;
      req_fire <= req_valid && req_ready && !reset;
      if (!reset && req_valid && req_ready) begin
         want = predict_verdict({req_kind, req_source_addr_high,
            req_source_addr_low, req_event_type, req_now_ms});
         expected_verdicts = {expected_verdicts, want};
         accepted_count <= accepted_count + 1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_verdicts.size() == 0) begin
            report_mismatch("unexpected response", 1, 0);
         end else begin
            want = expected_verdicts.pop_front();
            checked_count <= checked_count + 1;
            if (rsp_threat_level !== want.level)
               report_mismatch("threat_level", rsp_threat_level, want.level);
            if (rsp_level_changed !== want.changed)
               report_mismatch("level_changed", rsp_level_changed, want.changed);
            if (rsp_significant !== want.significant)
               report_mismatch("significant", rsp_significant, want.significant);
            if (rsp_entry_found !== want.found)
               report_mismatch("entry_found", rsp_entry_found, want.found);
            if (rsp_table_full !== want.full)
               report_mismatch("table_full", rsp_table_full, want.full);
            if (rsp_removed_count !== want.removed)
               report_mismatch("removed_count", rsp_removed_count, want.removed);
         end
      end
   end

   // driver: hold the request until accepted, then offer the next one
   always @(negedge clock) begin
      request_type r;
      if (!reset && (!req_valid || req_fire)) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            r = pending_requests.pop_front();
            req_valid <= 1'b1;
            req_kind <= r.kind;
            req_source_addr_high <= r.addr_hi;
            req_source_addr_low <= r.addr_lo;
            req_event_type <= r.ev;
            req_now_ms <= r.now;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus one long hold-off
   int  hold_left = 0;
   bit  hold_done = 0;
   always @(negedge clock) begin
      if (long_hold_trigger && !hold_done) begin
         hold_left <= 600;
         hold_done <= 1;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[source_threat_scoring_table_core] ERROR");
         $finish;
      end
   end

   task automatic add_request(logic [1:0] kind, logic [63:0] hi, logic [63:0] lo,
                              logic [3:0] ev, logic [63:0] now);
      request_type r;
      r = '{kind: kind, addr_hi: hi, addr_lo: lo, ev: ev, now: now};
      pending_requests = {pending_requests, r};
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      thresh[idx] = (idx < REG_WINDOW) ? {16'd0, value[15:0]} : value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic write_all(logic [31:0] rate_hi, logic [31:0] rate_lo,
                            logic [31:0] window, logic [31:0] interval);
      write_reg(REG_AUTH_HI, rate_hi);
      write_reg(REG_AUTH_LO, rate_lo);
      write_reg(REG_LIMIT_HI, rate_hi ^ 32'h0003_0001);
      write_reg(REG_LIMIT_LO, rate_lo);
      write_reg(REG_INVALID_HI, rate_hi);
      write_reg(REG_INVALID_LO, rate_lo ^ 32'h0001_0000);
      write_reg(REG_WINDOW, window);
      write_reg(REG_SWEEP, interval);
   endtask

   // mostly events on a small working set of sources so rates build up
   task automatic add_random(int count, int active);
      int k, sel;
      logic [3:0] ev;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(99);
         if (sel < 3) clock_ms += 64'd200_000_000;
         else if (sel < 15) clock_ms += 64'($urandom_range(400_000, 40_000));
         else clock_ms += 64'($urandom_range(6000));
         k = $urandom_range(active - 1);
         ev = ($urandom_range(3) != 0) ? 4'($urandom_range(2)) : 4'($urandom);
         sel = $urandom_range(99);
         if (sel < 3)
            add_request(KIND_EVENT, key_hi[k], key_lo[k], ev, {$urandom, $urandom});
         else if (sel < 70)
            add_request(KIND_EVENT, key_hi[k], key_lo[k], ev, clock_ms);
         else if (sel < 80)
            add_request(KIND_QUERY, key_hi[k], key_lo[k], ev, clock_ms);
         else if (sel < 84)
            add_request(KIND_QUERY, {$urandom, $urandom}, {$urandom, $urandom},
                        4'($urandom), {$urandom, $urandom});
         else if (sel < 97)
            add_request(KIND_TICK, {$urandom, $urandom}, {$urandom, $urandom},
                        4'($urandom), clock_ms);
         else
            add_request(KIND_RESERVED, {$urandom, $urandom}, {$urandom, $urandom},
                        4'($urandom), {$urandom, $urandom});
      end
   endtask

   initial begin
      thresh = '{100, 10, 100, 10, 100, 10, 3600000, 300000};
      slot_valid = '{default: 0};
      last_sweep_ms = '0;
      clock_ms = 64'd1_000_000;
      for (int i = 0; i < POOL; i++) begin
         key_hi[i] = {$urandom, $urandom};
         key_lo[i] = {$urandom, $urandom};
      end
      key_hi[0] = '1; key_lo[0] = '1;
      key_hi[1] = '0; key_lo[1] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: every kind, event type and time extreme, no idling
      add_request(KIND_QUERY, key_hi[0], key_lo[0], EV_AUTH, 64'd0);
      add_request(KIND_EVENT, key_hi[0], key_lo[0], EV_AUTH, 64'd0);
      add_request(KIND_EVENT, key_hi[1], key_lo[1], EV_LIMIT, '1);
      add_request(KIND_EVENT, key_hi[1], key_lo[1], EV_INVALID, 64'd5);
      for (int t = EV_PROTO_MIN; t < 16; t++)
         add_request(KIND_EVENT, key_hi[2], key_lo[2], 4'(t), 64'd1_000 + 64'(t) * 5000);
      add_request(KIND_EVENT, key_hi[2], key_lo[2], EV_AUTH, 64'd200_000);
      add_request(KIND_QUERY, key_hi[2], key_lo[2], EV_AUTH, 64'd0);
      add_request(KIND_RESERVED, key_hi[2], key_lo[2], EV_AUTH, 64'd300);
      add_request(KIND_TICK, '0, '0, EV_AUTH, 64'd100);
      add_request(KIND_TICK, '1, '1, 4'hF, 64'd400_000_000);
      add_request(KIND_QUERY, key_hi[1], key_lo[1], EV_AUTH, 64'd0);
      wait_drained();

      // fill the table past capacity, then age everything out
      write_all(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
      clock_ms = 64'd500_000_000;
      for (int i = 0; i < 70; i++)
         add_request(KIND_EVENT, key_hi[i % POOL] ^ 64'(i), key_lo[i % POOL], EV_LIMIT,
                     clock_ms + 64'(i));
      add_request(KIND_TICK, '0, '0, EV_AUTH, clock_ms + 64'd10);
      clock_ms += 64'd400_000_000;
      add_request(KIND_TICK, '0, '0, EV_AUTH, clock_ms);
      wait_drained();

      // random phases over several register settings and idling patterns
      write_all(32'd100, 32'd10, 32'd3_600_000, 32'd300_000);
      send_idle_pct = 0; recv_stall_pct = 0;
      long_hold_trigger = 1;
      add_random(140, 12);
      wait_drained();

      write_all(32'hFFFF, 32'hFFFF, 32'd0, 32'hFFFF_FFFF);
      send_idle_pct = 63; recv_stall_pct = 0;
      add_random(100, 20);
      wait_drained();

      write_all(32'd30, 32'd3, 32'd100_000, 32'd60_000);
      send_idle_pct = 0; recv_stall_pct = 63;
      add_random(130, 10);
      wait_drained();

      write_all($urandom, $urandom, $urandom, $urandom);
      send_idle_pct = 18; recv_stall_pct = 18;
      add_random(60, 16);
      wait_drained();
      write_all(32'd500, 32'd50, 32'd7_200_000, 32'd0);
      add_random(120, 8);
      wait_drained();

      $display("covered %0d requests, %0d responses checked, across seven register settings",
               accepted_count, checked_count);
      $display("including a full table, stale sweeps, a long response hold-off and idling");
      if (error_count == 0) begin
         $display("[source_threat_scoring_table_core] OK");
      end else begin
         $display("[source_threat_scoring_table_core] ERROR");
      end
      $finish;
   end

endmodule
